### design/cst_pkg.sv
// Shared constants and operation codes for the counting semaphore table.
`timescale 1ns / 1ps

package cst_pkg;

  // Fixed field widths of the command and result ports.
  localparam int OP_W     = 2;
  localparam int SEM_ID_W = 6;
  localparam int VALUE_W  = 32;
  localparam int PID_W    = 8;
  localparam int OPENER_W = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_OPEN  = 2'd0;
  localparam logic [OP_W-1:0] OP_WAIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_POST  = 2'd2;
  localparam logic [OP_W-1:0] OP_CLOSE = 2'd3;

  // Saturation limits.
  localparam logic [VALUE_W-1:0]  COUNT_MAX  = '1;
  localparam logic [OPENER_W-1:0] OPENER_MAX = '1;

  // Default configuration.
  localparam int DEF_NUM_SEMS    = 64;
  localparam int DEF_QUEUE_DEPTH = 16;
  localparam int DEF_PID_BITS    = 8;

endpackage

### design/counting_semaphore_table_core.sv
// Top level of the counting semaphore table: sequencer, entry RAM and waiter RAM.
`timescale 1ns / 1ps

// Channel   Direction  Signals                                         Transfer
// command   in         start, busy, operation, sem_id, init_value,     start & !busy
//                      caller_pid
// result    out        done, status, caller_blocks, wake_valid,        done
//                      wake_pid
//
// An accepted command reads its table entry in the cycle of acceptance and is
// executed in the next cycle, where the entry is written back; the result is
// shown in the cycle after that.
// A post that releases a waiter reads the waiter RAM as well, in a wake state.
// The next command may be accepted in the cycle in which the result is shown.
// After reset the block sweeps the entry RAM, one entry a cycle, to mark every
// semaphore as absent; busy stays high for the whole sweep.
// The receiver cannot stall: each result is on the ports for exactly one cycle.

module counting_semaphore_table_core
  import cst_pkg::*;
#(
  parameter int NUM_SEMS    = DEF_NUM_SEMS,
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
  parameter int PID_BITS    = DEF_PID_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OP_W-1:0]     operation,
  input  logic [SEM_ID_W-1:0] sem_id,
  input  logic [VALUE_W-1:0]  init_value,
  input  logic [PID_W-1:0]    caller_pid,
  output logic                done,
  output logic                status,
  output logic                caller_blocks,
  output logic                wake_valid,
  output logic [PID_W-1:0]    wake_pid
);

  // Widths derived from the configuration.
  localparam int SEM_AW  = $clog2(NUM_SEMS);
  localparam int HEAD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int FILL_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W   = FILL_W + 1;
  localparam int WQ_DEPTH = NUM_SEMS * QUEUE_DEPTH;
  localparam int WQ_AW   = (WQ_DEPTH > 1) ? $clog2(WQ_DEPTH) : 1;

  // Sequencer states.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_WAKE  = 2'd3;

  // One table entry as it is held in the entry RAM.
  typedef struct packed {
    logic                live;
    logic [VALUE_W-1:0]  count;
    logic [OPENER_W-1:0] openers;
    logic [HEAD_W-1:0]   head;
    logic [FILL_W-1:0]   fill;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  logic [1:0]          state;
  logic [1:0]          state_next;
  logic [SEM_AW-1:0]   clr_idx;

  // Command captured at acceptance.
  logic [OP_W-1:0]     op_q;
  logic [SEM_ID_W-1:0] id_q;
  logic [VALUE_W-1:0]  init_q;
  logic [PID_BITS-1:0] pid_q;

  logic                accept;
  logic [15:0]         in_id_ext;
  logic [15:0]         id_q_ext;
  logic [15:0]         pid_ext;
  logic [15:0]         wake_ext;
  logic [SEM_AW-1:0]   in_idx;
  logic [SEM_AW-1:0]   q_idx;
  logic                in_range;

  // Entry RAM ports.
  logic                ent_we;
  logic [SEM_AW-1:0]   ent_waddr;
  entry_t              ent_wdata;
  logic [ENTRY_W-1:0]  ent_rdata;
  entry_t              ent;
  entry_t              ent_new;
  logic                ent_upd;

  // Waiter RAM ports.
  logic                wq_we;
  logic [WQ_AW-1:0]    wq_base;
  logic [WQ_AW-1:0]    wq_waddr;
  logic [WQ_AW-1:0]    wq_raddr;
  logic [PID_BITS-1:0] wq_rdata;

  logic [SUM_W-1:0]    tail_sum;
  logic [HEAD_W-1:0]   tail_slot;
  logic [OPENER_W-1:0] openers_dec;

  // Result decided in the execute cycle.
  logic                res_status;
  logic                res_blocks;
  logic                res_emit;
  logic                go_wake;

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  assign in_id_ext = 16'(sem_id);
  assign id_q_ext  = 16'(id_q);
  assign in_idx    = in_id_ext[SEM_AW-1:0];
  assign q_idx     = id_q_ext[SEM_AW-1:0];
  assign in_range  = (32'(id_q) < 32'(NUM_SEMS));
  assign pid_ext   = 16'(caller_pid);
  assign wake_ext  = 16'(wq_rdata);
  assign ent       = entry_t'(ent_rdata);

  // Each semaphore owns QUEUE_DEPTH consecutive slots of the waiter RAM.
  assign wq_base = WQ_AW'(q_idx) * WQ_AW'(QUEUE_DEPTH);

  // The tail slot is the head plus the fill, wrapped once around the ring.
  always_comb begin
    tail_sum = SUM_W'(ent.head) + SUM_W'(ent.fill);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail_slot = tail_sum[HEAD_W-1:0];
  end

  assign wq_waddr = wq_base + WQ_AW'(tail_slot);
  assign wq_raddr = wq_base + WQ_AW'(ent.head);

  assign openers_dec = (ent.openers != '0) ? ent.openers - 1'b1 : '0;

  // Execute: modify the entry read in the previous cycle.
  always_comb begin
    ent_new    = ent;
    ent_upd    = 1'b0;
    wq_we      = 1'b0;
    res_status = 1'b0;
    res_blocks = 1'b0;
    go_wake    = 1'b0;
    if (state == ST_EXEC) begin
      if (!in_range) begin
        res_status = 1'b1;
      end else if (op_q == OP_OPEN) begin
        ent_upd = 1'b1;
        if (ent.live) begin
          if (ent.openers != OPENER_MAX) begin
            ent_new.openers = ent.openers + 1'b1;
          end
        end else begin
          ent_new.live    = 1'b1;
          ent_new.count   = init_q;
          ent_new.openers = OPENER_W'(1);
          ent_new.head    = '0;
          ent_new.fill    = '0;
        end
      end else if (!ent.live) begin
        res_status = 1'b1;
      end else begin
        unique case (op_q)
          OP_WAIT: begin
            if (ent.count != '0) begin
              ent_upd       = 1'b1;
              ent_new.count = ent.count - 1'b1;
            end else if (32'(ent.fill) < 32'(QUEUE_DEPTH)) begin
              ent_upd      = 1'b1;
              wq_we        = 1'b1;
              ent_new.fill = ent.fill + 1'b1;
              res_blocks   = 1'b1;
            end else begin
              res_status = 1'b1;
            end
          end
          OP_POST: begin
            ent_upd = 1'b1;
            if (ent.fill == '0) begin
              if (ent.count != COUNT_MAX) begin
                ent_new.count = ent.count + 1'b1;
              end
            end else begin
              go_wake      = 1'b1;
              ent_new.fill = ent.fill - 1'b1;
              if (32'(ent.head) == 32'(QUEUE_DEPTH - 1)) begin
                ent_new.head = '0;
              end else begin
                ent_new.head = ent.head + 1'b1;
              end
            end
          end
          OP_CLOSE: begin
            ent_upd         = 1'b1;
            ent_new.openers = openers_dec;
            if (openers_dec == '0) begin
              ent_new.live = 1'b0;
              ent_new.head = '0;
              ent_new.fill = '0;
            end
          end
          default: begin
            res_status = 1'b1;
          end
        endcase
      end
    end
  end

  assign res_emit = (state == ST_EXEC) && !go_wake;

  // The clearing sweep marks each entry absent; afterwards only execute writes.
  always_comb begin
    if (state == ST_CLEAR) begin
      ent_we    = 1'b1;
      ent_waddr = clr_idx;
      ent_wdata = '0;
    end else begin
      ent_we    = ent_upd;
      ent_waddr = q_idx;
      ent_wdata = ent_new;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == SEM_AW'(NUM_SEMS - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_next = go_wake ? ST_WAKE : ST_IDLE;
      end
      ST_WAKE: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
      done    <= 1'b0;
    end else begin
      state <= state_next;
      done  <= res_emit || (state == ST_WAKE);
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  // Command capture and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= operation;
      id_q   <= sem_id;
      init_q <= init_value;
      pid_q  <= pid_ext[PID_BITS-1:0];
    end
    if (res_emit) begin
      status        <= res_status;
      caller_blocks <= res_blocks;
      wake_valid    <= 1'b0;
      wake_pid      <= '0;
    end else if (state == ST_WAKE) begin
      status        <= 1'b0;
      caller_blocks <= 1'b0;
      wake_valid    <= 1'b1;
      wake_pid      <= wake_ext[PID_W-1:0];
    end
  end

  // The entry is read at the address on the command port; the value is used
  // only in the cycle after acceptance.
  cst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SEMS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (in_idx),
    .rdata (ent_rdata)
  );

  cst_ram #(
    .WIDTH (PID_BITS),
    .DEPTH (WQ_DEPTH)
  ) u_waiter_ram (
    .clk   (clk),
    .we    (wq_we),
    .waddr (wq_waddr),
    .wdata (pid_q),
    .raddr (wq_raddr),
    .rdata (wq_rdata)
  );

  // A result is only ever shown after an execute or wake cycle.
  assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(state) == ST_EXEC || $past(state) == ST_WAKE))
    else $error("result shown without a command in flight");

  // An accepted command always moves straight to execution.
  assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_EXEC))
    else $error("accepted command did not enter execution");

  // The entry RAM is never written while the block is idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!ent_we && !wq_we))
    else $error("table written while idle");

  // A blocked caller and a released waiter are never reported with an error.
  assert property (@(posedge clk) disable iff (rst)
    (done && (caller_blocks || wake_valid)) |-> (!status && !(caller_blocks && wake_valid)))
    else $error("inconsistent result flags");

  // The wake cycle follows only a post.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_WAKE) |-> ($past(state) == ST_EXEC && op_q == OP_POST))
    else $error("wake cycle without a post");

endmodule

### design/cst_ram.sv
// Generic single write port, single read port RAM with a registered read.
`timescale 1ns / 1ps

module cst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
